### sv/lfr_pkg.sv
// Shared types, codes and constants of the literal find-and-replace stream.
package lfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 13;
    localparam int LEN_W           = 4;
    localparam int LIMIT_W         = 13;
    localparam int WORD_W          = 64;
    localparam int CFG_IDX_W       = 3;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_LENGTH_LIMIT       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LIMIT = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RST     = 4'd1;
    localparam logic [LEN_W-1:0]   REPLACEMENT_LENGTH_RST = 4'd0;
    localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST       = 13'd1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take the accepted input byte into the lookahead buffer
        logic pop;         // release the front byte of the buffer
        logic repl_start;  // drop the matched bytes and start the replacement
        logic repl_emit;   // release the next replacement byte
        logic term;        // send the terminal item and clear the string state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;   // the output register can take an item this cycle
        logic count_zero;  // lookahead buffer is empty
        logic match;       // buffer holds the whole pattern
        logic need_pop;    // buffer front must be released before going on
        logic repl_done;   // every replacement byte has been released
    } t_sts;

endpackage

### sv/lfr_ctrl.sv
// Controller state machine that sequences the work for one input byte.
module lfr_ctrl
    import lfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_REPL,
        S_FLUSH,
        S_TERM
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_in_last;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_sts.match) begin
                    o_cmd.repl_start = 1'b1;
                    n_state          = S_REPL;
                end else if (i_sts.need_pop) begin
                    o_cmd.pop = i_sts.slot_free;
                end else begin
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_REPL: begin
                if (i_sts.repl_done) begin
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end else begin
                    o_cmd.repl_emit = i_sts.slot_free;
                end
            end
            S_FLUSH: begin
                if (i_sts.count_zero) begin
                    n_state = S_TERM;
                end else begin
                    o_cmd.pop = i_sts.slot_free;
                end
            end
            S_TERM: begin
                if (i_sts.slot_free) begin
                    o_cmd.term = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // Nothing may be sent while the output register is still occupied.
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pop || o_cmd.repl_emit || o_cmd.term) |-> i_sts.slot_free)
        else $error("emission commanded without a free output slot");

    // A string only ends once the lookahead buffer has been drained.
    a_term_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.term |-> i_sts.count_zero)
        else $error("terminal item sent with bytes still held");

    // A new byte is only taken after the previous one has been fully handled.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EVAL))
        else $error("byte taken without moving to evaluation");

endmodule

### sv/lfr_dpath.sv
// Datapath: configuration registers, lookahead buffer, counters and output register.
module lfr_dpath
    import lfr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_has_byte,
    output logic                 o_out_last,
    output logic [1:0]           o_status
);

    localparam int CNTW = $clog2(PATTERN_MAX + 1);
    localparam int IDXW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CMPW = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 1;

    // Configuration registers.
    logic [WORD_W-1:0]  r_pattern_bytes;
    logic [LEN_W-1:0]   r_pattern_length;
    logic [WORD_W-1:0]  r_replacement_bytes;
    logic [LEN_W-1:0]   r_replacement_length;
    logic [LIMIT_W-1:0] r_length_limit;

    // String state.
    t_byte                  r_buf [PATTERN_MAX];
    logic [CNTW-1:0]        r_count;
    logic [CNTW-1:0]        r_repl_cnt;
    logic [COUNT_WIDTH-1:0] r_input_count;
    logic [COUNT_WIDTH-1:0] r_output_count;
    logic                   r_limit_hit;

    // Output register.
    logic       r_out_valid;
    t_byte      r_out_byte;
    logic       r_has_byte;
    logic       r_out_last;
    t_status    r_status;

    t_byte                  pat [PATTERN_MAX];
    t_byte                  rep [PATTERN_MAX];
    logic [CNTW-1:0]        plen;
    logic [CNTW-1:0]        rlen;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] mask;
    logic                   prefix_ok;
    logic                   plen_zero;
    logic                   count_zero;
    logic                   emit_ok;
    logic                   byte_emit;
    logic                   taken;
    logic [COUNT_WIDTH-1:0] n_input_count;
    t_byte                  emit_byte;
    t_status                term_status;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat[i]  = r_pattern_bytes[8*i +: 8];
            rep[i]  = r_replacement_bytes[8*i +: 8];
            eq[i]   = (r_buf[i] == pat[i]);
            mask[i] = (CNTW'(i) < r_count);
        end
    end

    // Lengths above the buffer size behave as the buffer size.
    assign plen = (r_pattern_length > LEN_W'(PATTERN_MAX)) ? CNTW'(PATTERN_MAX)
                                                           : r_pattern_length[CNTW-1:0];
    assign rlen = (r_replacement_length > LEN_W'(PATTERN_MAX)) ? CNTW'(PATTERN_MAX)
                                                               : r_replacement_length[CNTW-1:0];

    assign prefix_ok  = &(eq | ~mask);
    assign plen_zero  = (plen == '0);
    assign count_zero = (r_count == '0);

    assign taken = r_out_valid && i_out_ready;

    assign o_sts.slot_free  = !r_out_valid || i_out_ready;
    assign o_sts.count_zero = count_zero;
    assign o_sts.match      = !plen_zero && (r_count == plen) && prefix_ok;
    // With an empty pattern every held byte goes out; otherwise bytes are released
    // until what is left is a proper prefix of the pattern.
    assign o_sts.need_pop   = plen_zero ? !count_zero
                                        : (!count_zero && ((r_count >= plen) || !prefix_ok));
    assign o_sts.repl_done  = (r_repl_cnt == rlen);

    // A byte goes out only while the output length stays below the limit.
    assign emit_ok   = (CMPW'(r_output_count) + CMPW'(1)) < CMPW'(r_length_limit);
    assign byte_emit = i_cmd.pop || i_cmd.repl_emit;
    assign emit_byte = i_cmd.pop ? r_buf[0] : rep[r_repl_cnt[IDXW-1:0]];

    assign n_input_count = (r_input_count != '1) ? r_input_count + COUNT_WIDTH'(1)
                                                 : r_input_count;

    assign term_status = r_limit_hit ? ST_LIMIT
                       : ((r_pattern_length == '0) ? ST_EMPTY : ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= PATTERN_LENGTH_RST;
            r_replacement_bytes  <= '0;
            r_replacement_length <= REPLACEMENT_LENGTH_RST;
            r_length_limit       <= LENGTH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES:      r_pattern_bytes      <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_pattern_length     <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_replacement_bytes  <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_replacement_length <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_LIMIT:       r_length_limit       <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lookahead buffer: append at the fill level, shift towards the front on release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (IDXW'(i) == r_count[IDXW-1:0]) begin
                    r_buf[i] <= i_in_byte;
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_repl_cnt     <= '0;
            r_input_count  <= '0;
            r_output_count <= '0;
            r_limit_hit    <= 1'b0;
        end else begin
            if (i_cmd.term) begin
                r_count        <= '0;
                r_input_count  <= '0;
                r_output_count <= '0;
                r_limit_hit    <= 1'b0;
            end else begin
                if (i_cmd.load) begin
                    r_count       <= r_count + CNTW'(1);
                    r_input_count <= n_input_count;
                    if (CMPW'(n_input_count) >= CMPW'(r_length_limit)) begin
                        r_limit_hit <= 1'b1;
                    end
                end
                if (i_cmd.pop) begin
                    r_count <= r_count - CNTW'(1);
                end
                if (i_cmd.repl_start) begin
                    r_count    <= '0;
                    r_repl_cnt <= '0;
                end
                if (i_cmd.repl_emit) begin
                    r_repl_cnt <= r_repl_cnt + CNTW'(1);
                end
                if (byte_emit) begin
                    if (emit_ok) begin
                        if (r_output_count != '1) begin
                            r_output_count <= r_output_count + COUNT_WIDTH'(1);
                        end
                    end else begin
                        r_limit_hit <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.term || (byte_emit && emit_ok)) begin
            r_out_valid <= 1'b1;
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.term) begin
            r_out_byte <= '0;
            r_has_byte <= 1'b0;
            r_out_last <= 1'b1;
            r_status   <= term_status;
        end else if (byte_emit && emit_ok) begin
            r_out_byte <= emit_byte;
            r_has_byte <= 1'b1;
            r_out_last <= 1'b0;
            r_status   <= ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_has_byte  = r_has_byte;
    assign o_out_last  = r_out_last;
    assign o_status    = r_status;

    // The buffer never holds more bytes than it has places.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(PATTERN_MAX))
        else $error("lookahead fill level beyond buffer depth");

    // A waiting transaction in the output register is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_out_byte) && $stable(r_out_last)))
        else $error("output register overwritten while stalled");

    // The terminal transaction leaves the string state cleared.
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.term |=> (r_count == '0 && r_output_count == '0 && !r_limit_hit))
        else $error("string state not cleared after terminal item");

endmodule

### sv/literal_find_replace_stream.sv
// Streaming literal find-and-replace: top level joining controller and datapath.
// Bytes of a string are taken one transaction at a time and every leftmost,
// non-overlapping occurrence of the configured pattern is replaced; up to
// pattern_length-1 bytes wait in a lookahead buffer until they either complete
// a match or are released. A byte is accepted only when the previous one has
// been fully handled: a byte that completes no match is evaluated and then
// releases bytes from the buffer one at a time, and a byte that completes a
// match drops the matched bytes and then sends each replacement byte. The
// controller sends one output transaction a cycle through a single output
// register while that register is free. The final byte of a string also
// releases every held byte and then sends the terminal transaction, which
// carries the status (0 ok, 1 length limit reached, 2 empty pattern).
// Configuration writes are taken in any cycle and must only be made while no
// string is in progress.
module literal_find_replace_stream
    import lfr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_has_byte,
    output logic                 o_out_last,
    output logic [1:0]           o_status
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfr_dpath #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_in_byte),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

### tb/literal_find_replace_stream_test.sv
// Self-checking testbench of the streaming literal find-and-replace block.
module literal_find_replace_stream_test;
    import lfr_pkg::*;

    localparam int PAT_MAX       = PATTERN_MAX_DEF;
    localparam int COUNT_MAX     = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 32;
    localparam int DIR_ROWS      = 39;

    typedef struct packed {
        logic [7:0] chr;
        logic       has_chr;
        logic       last;
        t_status    status;
    } t_item;

    // One row of the directed table: either a register write or one input byte.
    typedef struct packed {
        logic        cfg;
        t_cfg_idx    idx;
        logic [63:0] word;
        logic [7:0]  chr;
        logic        last;
        logic        typed;
        t_status     want;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PATTERN_BYTES;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_in_byte   = 8'h00;
    logic                 i_in_last   = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_has_byte;
    logic                 o_out_last;
    logic [1:0]           o_status;

    literal_find_replace_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Shadow registers and string state of the replacement predictor.
    logic [63:0] pat_word = '0;
    logic [3:0]  pat_len  = PATTERN_LENGTH_RST;
    logic [63:0] rep_word = '0;
    logic [3:0]  rep_len  = REPLACEMENT_LENGTH_RST;
    logic [12:0] limit    = LENGTH_LIMIT_RST;
    logic [7:0]  held [PAT_MAX];
    int          held_n   = 0;
    int          in_cnt   = 0;
    int          out_cnt  = 0;
    bit          lim_hit  = 1'b0;

    t_item results_due [$];
    t_item obs;
    t_item due;

    int send_idle   = 34;
    int recv_idle   = 88;
    int mismatches  = 0;
    int checked     = 0;
    int bytes_sent  = 0;
    int strings     = 0;
    int settings    = 0;

    t_row dir_plan [DIR_ROWS] = '{
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1'b1, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b1, 1'b1, ST_OK},
        '{1'b1, CFG_PATTERN_BYTES, 64'h6261, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_REPLACEMENT_BYTES, 64'h5A5958, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_REPLACEMENT_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h63, 1'b1, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h62, 1'b1, 1'b1, ST_EMPTY},
        '{1'b1, CFG_LENGTH_LIMIT, 64'd3, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h61, 1'b1, 1'b1, ST_LIMIT},
        '{1'b1, CFG_LENGTH_LIMIT, 64'd0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_LENGTH, 64'd8, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_BYTES, {64{1'b1}}, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_REPLACEMENT_LENGTH, 64'd8, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h11, 1'b1, 1'b1, ST_LIMIT},
        '{1'b1, CFG_LENGTH_LIMIT, 64'd4096, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_REPLACEMENT_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1'b1, ST_OK},
        '{1'b1, CFG_LENGTH_LIMIT, 64'd2, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b1, CFG_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b1, 1'b1, ST_LIMIT}
    };

    function automatic int clamp_len(logic [3:0] v);
        return (v > PAT_MAX) ? PAT_MAX : int'(v);
    endfunction

    function automatic logic [7:0] byte_at(logic [63:0] w, int i);
        return w[i*8 +: 8];
    endfunction

    function automatic void flag_mismatch(string what, t_item want, t_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH %s at %0t: expected byte %02h has %0d last %0d status %0d,",
                     what, $time, want.chr, want.has_chr, want.last, want.status);
            $display("    got byte %02h has %0d last %0d status %0d",
                     got.chr, got.has_chr, got.last, got.status);
        end
    endfunction

    // A byte goes out only while the output count stays below the limit.
    function automatic void release_char(logic [7:0] c);
        if (out_cnt + 1 < int'(limit)) begin
            results_due.push_back('{c, 1'b1, 1'b0, ST_OK});
            if (out_cnt < COUNT_MAX)
                out_cnt++;
        end else begin
            lim_hit = 1'b1;
        end
    endfunction

    function automatic void release_front();
        int i;
        if (held_n == 0)
            return;
        release_char(held[0]);
        for (i = 1; i < held_n; i++)
            held[i-1] = held[i];
        held_n--;
    endfunction

    function automatic bit held_is_prefix(int n);
        int i;
        for (i = 0; i < n; i++)
            if (held[i] != byte_at(pat_word, i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_replace(logic [7:0] c, logic last);
        int      plen;
        int      rlen;
        int      i;
        t_status st;
        plen = clamp_len(pat_len);
        rlen = clamp_len(rep_len);
        if (in_cnt < COUNT_MAX)
            in_cnt++;
        if (in_cnt >= int'(limit))
            lim_hit = 1'b1;
        if (held_n >= PAT_MAX)
            release_front();
        held[held_n] = c;
        held_n++;
        if (plen == 0) begin
            while (held_n > 0)
                release_front();
        end else begin
            while (held_n > plen)
                release_front();
            if (held_n == plen && held_is_prefix(plen)) begin
                for (i = 0; i < rlen; i++)
                    release_char(byte_at(rep_word, i));
                held_n = 0;
            end else begin
                // Rescan: drop leading bytes until the rest is a prefix again.
                while (held_n > 0 && (held_n >= plen || !held_is_prefix(held_n)))
                    release_front();
            end
        end
        if (last) begin
            while (held_n > 0)
                release_front();
            st = lim_hit ? ST_LIMIT : ((pat_len == 0) ? ST_EMPTY : ST_OK);
            results_due.push_back('{8'h00, 1'b0, 1'b1, st});
            in_cnt  = 0;
            out_cnt = 0;
            lim_hit = 1'b0;
        end
    endfunction

    // Leaves the config valid high so that back-to-back writes need no gap.
    task automatic write_reg(t_cfg_idx idx, logic [63:0] word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PATTERN_BYTES:      pat_word = word;
            CFG_PATTERN_LENGTH:     pat_len  = word[3:0];
            CFG_REPLACEMENT_BYTES:  rep_word = word;
            CFG_REPLACEMENT_LENGTH: rep_len  = word[3:0];
            CFG_LENGTH_LIMIT:       limit    = word[12:0];
            default: ;
        endcase
    endtask

    // Returns in the cycle of acceptance with valid still high; the next call
    // replaces the byte or lowers valid, or the drain lowers it, in that same time step.
    task automatic send_char(logic [7:0] c, logic last);
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= c;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_replace(c, last);
        bytes_sent++;
        if (last)
            strings++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_settings();
        int          r;
        logic [7:0]  sym [2];
        logic [63:0] w;
        int          i;
        r = $urandom_range(99);
        if (r < 6)
            write_reg(CFG_PATTERN_LENGTH, 64'd0);
        else if (r < 12)
            write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(9, 15)));
        else
            write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(1, 8)));
        // Half the patterns use two symbols only, so that they overlap themselves.
        w = {$urandom, $urandom};
        if ($urandom_range(1)) begin
            sym[0] = 8'($urandom);
            sym[1] = 8'($urandom);
            for (i = 0; i < PAT_MAX; i++)
                w[i*8 +: 8] = sym[$urandom_range(1)];
        end
        write_reg(CFG_PATTERN_BYTES, w);
        write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
        if ($urandom_range(99) < 8)
            write_reg(CFG_REPLACEMENT_LENGTH, 64'($urandom_range(9, 15)));
        else
            write_reg(CFG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 8)));
        r = $urandom_range(99);
        if (r < 15)
            write_reg(CFG_LENGTH_LIMIT, 64'($urandom_range(1, 24)));
        else if (r < 20)
            write_reg(CFG_LENGTH_LIMIT, 64'd4096);
        else
            write_reg(CFG_LENGTH_LIMIT, 64'($urandom_range(25, 1500)));
        settings++;
    endtask

    // Mostly whole and partial copies of the pattern, with near misses and noise.
    task automatic send_string(output int n);
        logic [7:0] text [$];
        int         target;
        int         plen;
        int         r;
        int         k;
        int         i;
        plen   = clamp_len(pat_len);
        target = $urandom_range(1, 24);
        while (text.size() < target) begin
            r = $urandom_range(99);
            if (plen == 0 || r >= 90) begin
                text.push_back(8'($urandom));
            end else if (r < 35) begin
                for (i = 0; i < plen; i++)
                    text.push_back(byte_at(pat_word, i));
            end else if (r < 55 && plen > 1) begin
                k = $urandom_range(1, plen - 1);
                for (i = 0; i < k; i++)
                    text.push_back(byte_at(pat_word, i));
            end else begin
                text.push_back(byte_at(pat_word, $urandom_range(0, plen - 1)));
            end
        end
        for (i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
        n = text.size();
    endtask

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            obs = '{o_out_byte, o_has_byte, o_out_last, t_status'(o_status)};
            if (results_due.size() == 0) begin
                flag_mismatch("unexpected transaction", '0, obs);
            end else begin
                due = results_due.pop_front();
                checked++;
                if (obs.chr !== due.chr || obs.has_chr !== due.has_chr ||
                    obs.last !== due.last || obs.status !== due.status)
                    flag_mismatch("result", due, obs);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int   r;
        int   regime;
        int   phase;
        int   n;
        int   phase_items;
        logic prev_cfg;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 1'b0;
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_plan[r].cfg) begin
                if (!prev_cfg)
                    drain();
                write_reg(dir_plan[r].idx, dir_plan[r].word);
            end else begin
                send_char(dir_plan[r].chr, dir_plan[r].last);
                if (dir_plan[r].typed && results_due[$].status != dir_plan[r].want)
                    flag_mismatch("terminal status", '{8'h00, 1'b0, 1'b1, dir_plan[r].want},
                                  results_due[$]);
            end
            prev_cfg = dir_plan[r].cfg;
        end

        for (regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin send_idle = 34; recv_idle = 88; end
                1: begin send_idle = 88; recv_idle = 34; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (phase = 0; phase < 4; phase++) begin
                drain();
                pick_settings();
                phase_items = 0;
                while (phase_items < PHASE_ITEMS) begin
                    send_string(n);
                    phase_items += n;
                end
            end
        end

        drain();
        $display("Checked %0d result transactions from %0d strings (%0d input bytes)",
                 checked, strings, bytes_sent);
        $display("over %0d random register settings plus the directed corner cases",
                 settings);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
